>>> hw/rtl/dlrs_pkg.sv
`default_nettype none
package dlrs_pkg;
   localparam int MaxElements = 64;
   localparam int ValW = 31;
   localparam int IdxW = $clog2(MaxElements);
   localparam int CntW = IdxW + 1;
   localparam int Radix = 10;
   localparam int DigW = 4;
   // digit of v in the current pass, from v divided by the weight
   typedef struct packed {
      logic          start;
      logic [ValW-1:0] dividend;
      logic [ValW-1:0] divisor;
   } div_req_type;
   typedef struct packed {
      logic          done;
      logic [DigW-1:0] digit;
   } div_rsp_type;
endpackage
`default_nettype wire

>>> hw/rtl/dlrs_digit_unit.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, then quotient mod 10.
module dlrs_digit_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  dlrs_pkg::div_req_type   req,
   output dlrs_pkg::div_rsp_type   rsp
);
   import dlrs_pkg::*;
   logic [ValW-1:0] quo_ff, quo_in;
   logic [ValW:0]   rem_ff, rem_in;
   logic [ValW-1:0] dvs_ff, dvs_in;
   logic [4:0]      bit_ff, bit_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DigW-1:0] dig_ff, dig_in;
   logic [ValW:0]   trial;
   logic [ValW-1:0] q_next;
   logic [ValW-1:0] q_div10;
   logic [ValW+35:0] prod;

   assign trial = {rem_ff[ValW-1:0], quo_ff[ValW-1]} - {1'b0, dvs_ff};
   // q/10 via reciprocal multiply (exact for 31-bit q)
   assign prod    = {5'd0, q_next} * 36'h0CCCCCCCD;
   assign q_div10 = prod[ValW+34:35];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dig_in  = dig_ff;
      q_next  = {quo_ff[ValW-2:0], ~trial[ValW]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         bit_in  = 5'(ValW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial[ValW] ? {rem_ff[ValW-1:0], quo_ff[ValW-1]} : trial;
         quo_in = q_next;
         bit_in = bit_ff - 5'd1;
         if (bit_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            dig_in  = DigW'(q_next - ValW'(q_div10 * ValW'(Radix)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      bit_ff <= bit_in;
      dig_ff <= dig_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.digit = dig_ff;

`ifndef NO_ASSERTIONS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> dig_ff < DigW'(Radix)) else $error("digit out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("start while busy");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/decimal_lsd_radix_sorter_core.sv
`default_nettype none
// LSD decimal radix sorter. Words are loaded one per cycle
// until one with tlast; a word past 64 stored is dropped. Then one counting
// pass runs per decimal digit of the largest value (none if all are zero).
// Each pass has a setup step, a count, prefix sums, a scatter and a copy
// back; the bit-serial divider that extracts each digit sets the pace.
// Results then stream out, a memory read before each word, holding under
// back-pressure, with tlast on the last; the core then rearms for input.
// No input is taken until done.
module decimal_lsd_radix_sorter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] value, [31] zero
   input  wire logic        req_tlast,   // last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [30:0] sorted_value, [31] zero
   output      logic        rsp_tlast    // final_res
);
   import dlrs_pkg::*;

   typedef enum logic [8:0] {
      S_LOAD  = 9'b000000001,
      S_DIGS  = 9'b000000010,
      S_CNT   = 9'b000000100,
      S_PFX   = 9'b000001000,
      S_SCAT  = 9'b000010000,
      S_COPY  = 9'b000100000,
      S_WAIT  = 9'b001000000,
      S_EMIT  = 9'b010000000,
      S_RD    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [ValW-1:0] elem_mem [MaxElements];
   logic [ValW-1:0] scr_mem  [MaxElements];
   logic [CntW-1:0] cnt_ff [Radix];
   logic [CntW-1:0] cnt_in [Radix];
   logic [CntW-1:0] n_ff, n_in;
   logic [CntW-1:0] i_ff, i_in;
   logic [ValW-1:0] max_ff, max_in;
   logic [ValW-1:0] wt_ff, wt_in;
   logic            scat_ff, scat_in;     // scatter half of the pass
   logic            sub_ff, sub_in;       // 0: issue read, 1: divide running
   logic [ValW-1:0] rd_ff;
   logic [ValW-1:0] srd_ff;
   logic [IdxW-1:0] rd_addr, srd_addr;
   logic            we_e, we_s;
   logic [IdxW-1:0] we_e_addr, we_s_addr;
   logic [ValW-1:0] we_e_data;
   logic [3:0]      pfx_ff, pfx_in;
   logic            ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [ValW-1:0] odata_ff, odata_in;
   div_req_type     dreq;
   div_rsp_type     drsp;
   logic [ValW+3:0] wt10;
   logic [CntW-1:0] pos;

   dlrs_digit_unit u_digit (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign wt10 = {wt_ff, 3'b000} + {2'b00, wt_ff, 1'b0};
   assign pos  = cnt_ff[drsp.digit] - CntW'(1);

   always_ff @(posedge clock) begin
      if (we_e) elem_mem[we_e_addr] <= we_e_data;
      if (we_s) scr_mem[we_s_addr] <= rd_ff;
      rd_ff  <= elem_mem[rd_addr];
      srd_ff <= scr_mem[srd_addr];
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      max_in    = max_ff;
      wt_in     = wt_ff;
      scat_in   = scat_ff;
      sub_in    = sub_ff;
      pfx_in    = pfx_ff;
      cnt_in    = cnt_ff;
      ovalid_in = ovalid_ff;
      olast_in  = olast_ff;
      odata_in  = odata_ff;
      rd_addr   = i_ff[IdxW-1:0];
      srd_addr  = i_ff[IdxW-1:0];
      we_e      = 1'b0;
      we_e_addr = n_ff[IdxW-1:0];
      we_e_data = req_tdata[ValW-1:0];
      we_s      = 1'b0;
      we_s_addr = pos[IdxW-1:0];
      dreq.start    = 1'b0;
      dreq.dividend = rd_ff;
      dreq.divisor  = wt_ff;
      req_tready = (state_ff == S_LOAD);
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (n_ff < CntW'(MaxElements)) begin
                  we_e = 1'b1;
                  n_in = n_ff + CntW'(1);
                  if (req_tdata[ValW-1:0] > max_in) max_in = req_tdata[ValW-1:0];
               end
               if (req_tlast) begin
                  wt_in    = ValW'(1);
                  state_in = S_DIGS;
               end
            end
         end
         S_DIGS: begin
            // pass needed while weight <= max
            if (max_ff >= wt_ff) begin
               i_in = '0;
               sub_in = 1'b0;
               scat_in = 1'b0;
               for (int k = 0; k < Radix; k++) cnt_in[k] = '0;
               state_in = S_CNT;
            end else begin
               i_in = '0;
               state_in = S_RD;
            end
         end
         S_CNT: begin
            if (i_ff == n_ff) begin
               pfx_in = 4'd1;
               state_in = S_PFX;
            end else if (!sub_ff) begin
               // rd_ff holds element i next cycle
               sub_in = 1'b1;
               state_in = S_WAIT;
            end else if (drsp.done) begin
               cnt_in[drsp.digit] = cnt_ff[drsp.digit] + CntW'(1);
               i_in = i_ff + CntW'(1);
               sub_in = 1'b0;
            end
         end
         S_WAIT: begin
            dreq.start = 1'b1;
            state_in = scat_ff ? S_SCAT : S_CNT;
         end
         S_PFX: begin
            cnt_in[pfx_ff] = cnt_ff[pfx_ff] + cnt_ff[pfx_ff - 4'd1];
            if (pfx_ff == 4'(Radix - 1)) begin
               pfx_in = 4'd0;
               i_in = n_ff;
               sub_in = 1'b0;
               scat_in = 1'b1;
               state_in = S_SCAT;
            end else begin
               pfx_in = pfx_ff + 4'd1;
            end
         end
         S_SCAT: begin
            rd_addr = IdxW'(i_ff - CntW'(1));
            if (i_ff == '0) begin
               i_in = '0;
               sub_in = 1'b0;
               state_in = S_COPY;
            end else if (!sub_ff) begin
               sub_in = 1'b1;
               state_in = S_WAIT;
            end else if (drsp.done) begin
               we_s = 1'b1;
               cnt_in[drsp.digit] = pos;
               i_in = i_ff - CntW'(1);
               sub_in = 1'b0;
            end
         end
         S_COPY: begin
            // srd_ff is the registered read of the previous address
            if (sub_ff) begin
               we_e = 1'b1;
               we_e_addr = IdxW'(i_ff - CntW'(1));
               we_e_data = srd_ff;
            end
            if (i_ff == n_ff) begin
               sub_in = 1'b0;
               if ({4'd0, max_ff} >= wt10) begin
                  wt_in = ValW'(wt10);
                  state_in = S_DIGS;
               end else begin
                  i_in = '0;
                  state_in = S_RD;
               end
            end else begin
               sub_in = 1'b1;
               i_in = i_ff + CntW'(1);
            end
         end
         S_RD: begin
            // registered memory read before each output word
            if (!ovalid_ff || rsp_tready) begin
               if (i_ff == n_ff) begin
                  ovalid_in = 1'b0;
                  n_in = '0; max_in = '0; wt_in = ValW'(1);
                  state_in = S_LOAD;
               end else begin
                  ovalid_in = 1'b0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            ovalid_in = 1'b1;
            odata_in  = rd_ff;
            olast_in  = (i_ff + CntW'(1) == n_ff);
            i_in      = i_ff + CntW'(1);
            state_in  = S_RD;
         end
         default: state_in = S_LOAD;
      endcase
      if (ovalid_ff && rsp_tready && state_ff != S_EMIT) ovalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         n_ff      <= '0;
         max_ff    <= '0;
         wt_ff     <= ValW'(1);
         ovalid_ff <= 1'b0;
         sub_ff    <= 1'b0;
         pfx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         max_ff    <= max_in;
         wt_ff     <= wt_in;
         ovalid_ff <= ovalid_in;
         sub_ff    <= sub_in;
         pfx_ff    <= pfx_in;
      end
      i_ff     <= i_in;
      scat_ff  <= scat_in;
      cnt_ff   <= cnt_in;
      olast_ff <= olast_in;
      odata_ff <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {1'b0, odata_ff};
   assign rsp_tlast  = olast_ff;

`ifndef NO_ASSERTIONS
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_LOAD) else $error("ready outside load");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CntW'(MaxElements)) else $error("count overflow");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output dropped");
`endif
endmodule
`default_nettype wire
